// ===== rtl/core/pmp_pkg.sv =====
package pmp_pkg;

  // Field and register widths.
  localparam int LAT_W       = 24;
  localparam int LON_W       = 25;
  localparam int PIX_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 25;
  localparam int ROT_W       = 32;

  // Pipeline depth outside the rotation chain.
  localparam int FRONT_LAT   = 7;
  localparam int BACK_LAT    = 7;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_LON   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_AT_45 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LAT_OFFSET   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LAT_GAIN     = 3'd5;

  // Register values after reset.
  localparam logic signed [24:0] RST_CENTER_LON   = 25'sd655360;
  localparam logic signed [15:0] RST_ORIGIN_X     = 16'sd447;
  localparam logic signed [15:0] RST_ORIGIN_Y     = -16'sd3552;
  localparam logic [15:0]        RST_RADIUS_AT_45 = 16'd4126;
  localparam logic [23:0]        RST_LAT_OFFSET   = 24'd6193152;
  localparam logic [17:0]        RST_LAT_GAIN     = 18'd72090;

  // Degrees to radians in Q32, and the rotation gain compensation in Q30.
  localparam logic [27:0] DEG_TO_RAD_Q32  = 28'd74961321;
  localparam logic [ROT_W-1:0] CORDIC_GAIN_Q30 = 32'd652032874;

  // Reciprocal of 45 for dividends below 2^22.
  localparam logic [22:0] RECIP45   = 23'd5965233;
  localparam int          RECIP45_SH = 28;

  // Arctangent of 2^-i in Q30 radians, truncated.
  localparam logic [ROT_W-1:0] ATAN_Q30 [32] = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
    32'd67021686,  32'd33543515,  32'd16775850,  32'd8388437,
    32'd4194282,   32'd2097149,   32'd1048575,   32'd524287,
    32'd262143,    32'd131071,    32'd65535,     32'd32767,
    32'd16383,     32'd8191,      32'd4095,      32'd2047,
    32'd1023,      32'd511,       32'd255,       32'd127,
    32'd63,        32'd31,        32'd15,        32'd8,
    32'd4,         32'd2,         32'd1,         32'd0
  };

  // Rotation state handed from cell to cell.
  typedef struct packed {
    logic signed [ROT_W-1:0] x;
    logic signed [ROT_W-1:0] y;
    logic signed [ROT_W-1:0] z;
  } pmp_rot_t;

  // Per-point flags that ride along the chain.
  typedef struct packed {
    logic flip;
    logic dneg;
  } pmp_ctrl_t;

endpackage

// ===== rtl/core/pmp_front.sv =====
module pmp_front #(
  parameter int FRACTION_BITS = 16,
  parameter int DMW           = 26
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [pmp_pkg::LAT_W-1:0]  latitude_i,
  input  logic signed [pmp_pkg::LON_W-1:0]  longitude_i,
  input  logic signed [24:0]                center_lon_i,
  input  logic [23:0]                       lat_offset_i,
  input  logic [17:0]                       lat_gain_i,
  output pmp_pkg::pmp_rot_t                 rot_o,
  output pmp_pkg::pmp_ctrl_t                ctrl_o,
  output logic [DMW-1:0]                    dmag_o
);
  import pmp_pkg::*;

  localparam int     F       = FRACTION_BITS;
  localparam int     TW      = 42 - F;
  localparam int     DW      = DMW + 1;
  localparam longint ONE     = longint'(1) << F;
  localparam longint FULL    = 360 * ONE;
  localparam longint HALF    = 180 * ONE;
  localparam longint QUARTER = 90 * ONE;
  localparam longint KFULL   = ((longint'(1) << 25) + FULL - 1) / FULL * FULL;
  localparam int     UW      = $clog2((longint'(1) << 25) + HALF + KFULL);
  localparam int     VW      = UW - (F + 3);
  localparam int     KV      = VW + 6;
  localparam longint MV      = ((longint'(1) << KV) + 44) / 45;
  localparam int     PVW     = VW + KV - 5;
  localparam int     AW      = F + 9;
  localparam int     ZPW     = AW + 28;

  localparam logic signed [41:0]    GL_BIAS   = 42'((longint'(1) << F) - 1);
  localparam logic signed [41:0]    GL_ZERO   = 42'(0);
  localparam logic [UW:0]           AD_OFS    = (UW + 1)'(HALF + KFULL);
  localparam logic signed [AW-1:0]  HALF_A    = AW'(HALF);
  localparam logic signed [AW-1:0]  QUART_A   = AW'(QUARTER);
  localparam logic signed [AW-1:0]  NQUART_A  = AW'(-QUARTER);
  localparam logic signed [27:0]    DEG_S     = 28'(DEG_TO_RAD_Q32);
  localparam logic signed [ZPW-1:0] ZP_BIAS   = ZPW'((longint'(1) << (F + 2)) - 1);
  localparam logic signed [ZPW-1:0] ZP_ZERO   = ZPW'(0);

  // Stage 1: latitude product and raw angle.
  logic signed [41:0] s1_gl_q;
  logic signed [25:0] s1_ad_q;
  // Stage 2: truncated product and angle biased positive.
  logic signed [TW-1:0] s2_t_q;
  logic [UW-1:0]        s2_u_q;
  // Stage 3: radius numerator and turn count.
  logic signed [DW-1:0] s3_d_q;
  logic [VW-1:0]        s3_v_q;
  logic [VW-1:0]        s3_q_q;
  logic [F+2:0]         s3_ul_q;
  // Stage 4: magnitude and angle in [-180, 180).
  logic [DMW-1:0]       s4_dmag_q;
  logic                 s4_dneg_q;
  logic signed [AW-1:0] s4_a_q;
  // Stage 5: angle folded to [-90, 90].
  logic [DMW-1:0]       s5_dmag_q;
  logic                 s5_dneg_q;
  logic signed [AW-1:0] s5_af_q;
  logic                 s5_flip_q;
  // Stage 6: angle scaled to radians.
  logic [DMW-1:0]        s6_dmag_q;
  logic                  s6_dneg_q;
  logic signed [ZPW-1:0] s6_zp_q;
  logic                  s6_flip_q;
  // Stage 7: rotation start angle.
  logic [DMW-1:0]          s7_dmag_q;
  logic                    s7_dneg_q;
  logic signed [ROT_W-1:0] s7_z_q;
  logic                    s7_flip_q;

  logic signed [41:0]    gl_adj;
  logic [UW:0]           ad_ext;
  logic [PVW-1:0]        q_prod;
  logic [VW-1:0]         rem45;
  logic signed [ZPW-1:0] zp_adj;

  // Rounding toward zero, modulo reduction and scaling helpers.
  always_comb begin
    gl_adj = s1_gl_q + (s1_gl_q[41] ? GL_BIAS : GL_ZERO);
    ad_ext = {{(UW - 25){s1_ad_q[25]}}, s1_ad_q};
    q_prod = PVW'(s2_u_q[UW-1:F+3]) * PVW'(MV);
    rem45  = s3_v_q - s3_q_q * VW'(45);
    zp_adj = s6_zp_q + (s6_zp_q[ZPW-1] ? ZP_BIAS : ZP_ZERO);
  end

  // Front pipeline registers; all stages advance together.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_gl_q <= $signed({1'b0, lat_gain_i}) * latitude_i;
      s1_ad_q <= {longitude_i[24], longitude_i} - {center_lon_i[24], center_lon_i};

      s2_t_q <= TW'(gl_adj >>> F);
      s2_u_q <= UW'(ad_ext + AD_OFS);

      s3_d_q  <= $signed({{(DW - 24){1'b0}}, lat_offset_i})
                 - $signed({{(DW - TW){s2_t_q[TW-1]}}, s2_t_q});
      s3_v_q  <= s2_u_q[UW-1:F+3];
      s3_q_q  <= VW'(q_prod >> KV);
      s3_ul_q <= s2_u_q[F+2:0];

      s4_dneg_q <= s3_d_q[DW-1];
      s4_dmag_q <= DMW'(s3_d_q[DW-1] ? -s3_d_q : s3_d_q);
      s4_a_q    <= $signed({rem45[5:0], s3_ul_q}) - HALF_A;

      s5_dmag_q <= s4_dmag_q;
      s5_dneg_q <= s4_dneg_q;
      if (s4_a_q > QUART_A) begin
        s5_af_q   <= s4_a_q - HALF_A;
        s5_flip_q <= 1'b1;
      end else if (s4_a_q < NQUART_A) begin
        s5_af_q   <= s4_a_q + HALF_A;
        s5_flip_q <= 1'b1;
      end else begin
        s5_af_q   <= s4_a_q;
        s5_flip_q <= 1'b0;
      end

      s6_dmag_q <= s5_dmag_q;
      s6_dneg_q <= s5_dneg_q;
      s6_zp_q   <= s5_af_q * DEG_S;
      s6_flip_q <= s5_flip_q;

      s7_dmag_q <= s6_dmag_q;
      s7_dneg_q <= s6_dneg_q;
      s7_z_q    <= ROT_W'(zp_adj >>> (F + 2));
      s7_flip_q <= s6_flip_q;
    end
  end

  assign rot_o.x     = CORDIC_GAIN_Q30;
  assign rot_o.y     = '0;
  assign rot_o.z     = s7_z_q;
  assign ctrl_o.flip = s7_flip_q;
  assign ctrl_o.dneg = s7_dneg_q;
  assign dmag_o      = s7_dmag_q;

endmodule

// ===== rtl/core/pmp_cell.sv =====
module pmp_cell #(
  parameter int STAGE_IDX = 0,
  parameter int DMW       = 26,
  parameter int BPC       = 2
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  pmp_pkg::pmp_rot_t  rot_i,
  input  pmp_pkg::pmp_ctrl_t ctrl_i,
  input  logic [DMW-1:0]     dmag_i,
  input  logic [DMW-1:0]     quot_i,
  input  logic [5:0]         rem_i,
  output pmp_pkg::pmp_rot_t  rot_o,
  output pmp_pkg::pmp_ctrl_t ctrl_o,
  output logic [DMW-1:0]     dmag_o,
  output logic [DMW-1:0]     quot_o,
  output logic [5:0]         rem_o
);
  import pmp_pkg::*;

  localparam int DIW = $clog2(DMW);

  logic signed [ROT_W-1:0] x_sh;
  logic signed [ROT_W-1:0] y_sh;
  pmp_rot_t                rot_d;
  logic [DMW-1:0]          quot_d;
  logic [5:0]              rem_d;
  logic [6:0]              trial;

  pmp_rot_t       rot_q;
  pmp_ctrl_t      ctrl_q;
  logic [DMW-1:0] dmag_q;
  logic [DMW-1:0] quot_q;
  logic [5:0]     rem_q;

  // One micro-rotation by atan(2^-STAGE_IDX), direction from the sign of z.
  always_comb begin
    x_sh = $signed(rot_i.x) >>> STAGE_IDX;
    y_sh = $signed(rot_i.y) >>> STAGE_IDX;
    if (!rot_i.z[ROT_W-1]) begin
      rot_d.x = rot_i.x - y_sh;
      rot_d.y = rot_i.y + x_sh;
      rot_d.z = rot_i.z - $signed(ATAN_Q30[STAGE_IDX]);
    end else begin
      rot_d.x = rot_i.x + y_sh;
      rot_d.y = rot_i.y - x_sh;
      rot_d.z = rot_i.z + $signed(ATAN_Q30[STAGE_IDX]);
    end
  end

  // Long division of the radius numerator by 45, BPC dividend bits per cell.
  always_comb begin
    trial  = '0;
    quot_d = quot_i;
    rem_d  = rem_i;
    for (int j = 0; j < BPC; j++) begin
      if (DMW - 1 - STAGE_IDX * BPC - j >= 0) begin
        trial = {rem_d, dmag_i[DIW'(DMW - 1 - STAGE_IDX * BPC - j)]};
        if (trial >= 7'd45) begin
          trial = trial - 7'd45;
          quot_d[DIW'(DMW - 1 - STAGE_IDX * BPC - j)] = 1'b1;
        end
        rem_d = trial[5:0];
      end
    end
  end

  // Cell registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_q  <= rot_d;
      ctrl_q <= ctrl_i;
      dmag_q <= dmag_i;
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
  end

  assign rot_o  = rot_q;
  assign ctrl_o = ctrl_q;
  assign dmag_o = dmag_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/core/pmp_back.sv =====
module pmp_back #(
  parameter int FRACTION_BITS = 16,
  parameter int DMW           = 26
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  pmp_pkg::pmp_rot_t                 rot_i,
  input  pmp_pkg::pmp_ctrl_t                ctrl_i,
  input  logic [DMW-1:0]                    quot_i,
  input  logic [5:0]                        rem_i,
  input  logic [15:0]                       radius_at_45_i,
  input  logic signed [15:0]                origin_x_i,
  input  logic signed [15:0]                origin_y_i,
  output logic signed [pmp_pkg::PIX_W-1:0]  pixel_x_o,
  output logic signed [pmp_pkg::PIX_W-1:0]  pixel_y_o,
  output logic                              clipped_o
);
  import pmp_pkg::*;

  localparam int F      = FRACTION_BITS;
  localparam int QDW    = DMW - 5;
  localparam int P1W    = 16 + QDW;
  localparam int RMW    = P1W + 1;
  localparam int RMAG_W = (RMW > 33) ? RMW : 33;
  localparam int RHW    = RMAG_W - 32;
  localparam int PW     = RMAG_W + 3;
  localparam int SW     = ((PW + 1 > 16 + F) ? PW + 1 : 16 + F) + 1;

  localparam logic signed [SW-1:0] S_BIAS = SW'((longint'(1) << F) - 1);
  localparam logic signed [SW-1:0] S_ZERO = SW'(0);
  localparam logic signed [SW-1:0] SAT_HI = SW'(32767);
  localparam logic signed [SW-1:0] SAT_LO = SW'(-32768);

  // Lane 0 carries sine and gives pixel_x, lane 1 carries cosine and gives pixel_y.
  logic signed [ROT_W-1:0] b1_trig_q [2];
  logic [P1W-1:0]          b1_p1_q;
  logic [21:0]             b1_p2_q;
  logic                    b1_dneg_q;

  logic signed [ROT_W-1:0] b2_trig_q [2];
  logic [P1W-1:0]          b2_p1_q;
  logic [15:0]             b2_q2_q;
  logic                    b2_dneg_q;

  logic [RMAG_W-1:0]       b3_rmag_q;
  logic [ROT_W-1:0]        b3_mt_q [2];
  logic                    b3_neg_q [2];

  logic [63:0]             b4_pl_q [2];
  logic [RHW+31:0]         b4_ph_q [2];
  logic                    b4_neg_q [2];

  logic [PW-1:0]           b5_pm_q [2];
  logic                    b5_neg_q [2];

  logic signed [SW-1:0]    b6_s_q [2];
  logic signed [SW-1:0]    b7_v_q [2];

  logic signed [SW-1:0]    org [2];
  logic signed [SW-1:0]    s_adj [2];
  logic [44:0]             q2_prod;
  logic signed [15:0]      pix [2];
  logic                    clip [2];

  // Origins in the same fixed-point format as the products.
  always_comb begin
    org[0]  = {{(SW - 16 - F){origin_x_i[15]}}, origin_x_i, {F{1'b0}}};
    org[1]  = {{(SW - 16 - F){origin_y_i[15]}}, origin_y_i, {F{1'b0}}};
    q2_prod = 45'(b1_p2_q) * 45'(RECIP45);
    for (int k = 0; k < 2; k++) begin
      s_adj[k] = b6_s_q[k] + (b6_s_q[k][SW-1] ? S_BIAS : S_ZERO);
    end
  end

  // Radius assembly, scaling by sine and cosine, and origin offset.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b1_trig_q[0] <= ctrl_i.flip ? -rot_i.y : rot_i.y;
      b1_trig_q[1] <= ctrl_i.flip ? -rot_i.x : rot_i.x;
      b1_p1_q      <= P1W'(radius_at_45_i) * P1W'(quot_i[QDW-1:0]);
      b1_p2_q      <= 22'(radius_at_45_i) * 22'(rem_i);
      b1_dneg_q    <= ctrl_i.dneg;

      b2_trig_q <= b1_trig_q;
      b2_p1_q   <= b1_p1_q;
      b2_q2_q   <= 16'(q2_prod >> RECIP45_SH);
      b2_dneg_q <= b1_dneg_q;

      b3_rmag_q <= RMAG_W'(b2_p1_q) + RMAG_W'(b2_q2_q);
      for (int k = 0; k < 2; k++) begin
        b3_mt_q[k]  <= b2_trig_q[k][ROT_W-1] ? ROT_W'(-b2_trig_q[k]) : b2_trig_q[k];
        b3_neg_q[k] <= b2_dneg_q ^ b2_trig_q[k][ROT_W-1];
      end

      for (int k = 0; k < 2; k++) begin
        b4_pl_q[k]  <= 64'(b3_rmag_q[31:0]) * 64'(b3_mt_q[k]);
        b4_ph_q[k]  <= (RHW + 32)'(b3_rmag_q[RMAG_W-1:32]) * (RHW + 32)'(b3_mt_q[k]);
        b4_neg_q[k] <= b3_neg_q[k];
      end

      for (int k = 0; k < 2; k++) begin
        b5_pm_q[k]  <= PW'({b4_ph_q[k], 2'b00}) + PW'(b4_pl_q[k][63:30]);
        b5_neg_q[k] <= b4_neg_q[k];
      end

      for (int k = 0; k < 2; k++) begin
        b6_s_q[k] <= b5_neg_q[k] ? org[k] - $signed(SW'(b5_pm_q[k]))
                                 : org[k] + $signed(SW'(b5_pm_q[k]));
      end

      for (int k = 0; k < 2; k++) begin
        b7_v_q[k] <= s_adj[k] >>> F;
      end
    end
  end

  // Saturation to the 16-bit pixel range.
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      if (b7_v_q[k] > SAT_HI) begin
        pix[k]  = 16'sh7fff;
        clip[k] = 1'b1;
      end else if (b7_v_q[k] < SAT_LO) begin
        pix[k]  = -16'sh8000;
        clip[k] = 1'b1;
      end else begin
        pix[k]  = b7_v_q[k][15:0];
        clip[k] = 1'b0;
      end
    end
  end

  assign pixel_x_o = pix[0];
  assign pixel_y_o = pix[1];
  assign clipped_o = clip[0] | clip[1];

endmodule

// ===== rtl/core/polar_map_projection.sv =====
// Polar map projection: maps a latitude/longitude point (signed degrees with
// FRACTION_BITS fraction bits) to pixel coordinates around the pole, with a
// flag when either coordinate saturates. The block is fully pipelined and
// accepts one request per clock while not stalled. The accepting edge loads
// the first of 7 front stages for the radius numerator and angle reduction.
// The request then passes one rotation cell per CORDIC stage, 7 stages of
// radius scaling and products, and the output register. A two-entry output
// buffer lets one more request enter while a result waits; the input stalls
// only when that buffer is full. Configuration writes take effect at once
// and must only be made while no request is in flight.
module polar_map_projection #(
  parameter int CORDIC_STAGES = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [pmp_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [pmp_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [pmp_pkg::LAT_W-1:0]      latitude_i,
  input  logic signed [pmp_pkg::LON_W-1:0]      longitude_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [pmp_pkg::PIX_W-1:0]      pixel_x_o,
  output logic signed [pmp_pkg::PIX_W-1:0]      pixel_y_o,
  output logic                                  clipped_o
);
  import pmp_pkg::*;

  localparam int TW  = 42 - FRACTION_BITS;
  localparam int DW  = ((TW > 25) ? TW : 25) + 1;
  localparam int DMW = DW - 1;
  localparam int BPC = (DMW + CORDIC_STAGES - 1) / CORDIC_STAGES;
  localparam int LAT = FRONT_LAT + CORDIC_STAGES + BACK_LAT;

  // Configuration registers.
  logic signed [24:0] center_lon_q;
  logic signed [15:0] origin_x_q;
  logic signed [15:0] origin_y_q;
  logic [15:0]        radius_at_45_q;
  logic [23:0]        lat_offset_q;
  logic [17:0]        lat_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_lon_q   <= RST_CENTER_LON;
      origin_x_q     <= RST_ORIGIN_X;
      origin_y_q     <= RST_ORIGIN_Y;
      radius_at_45_q <= RST_RADIUS_AT_45;
      lat_offset_q   <= RST_LAT_OFFSET;
      lat_gain_q     <= RST_LAT_GAIN;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CENTER_LON:   center_lon_q   <= cfg_data_i[24:0];
        CFG_ORIGIN_X:     origin_x_q     <= cfg_data_i[15:0];
        CFG_ORIGIN_Y:     origin_y_q     <= cfg_data_i[15:0];
        CFG_RADIUS_AT_45: radius_at_45_q <= cfg_data_i[15:0];
        CFG_LAT_OFFSET:   lat_offset_q   <= cfg_data_i[23:0];
        CFG_LAT_GAIN:     lat_gain_q     <= cfg_data_i[17:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline advances unless the output buffer is full.
  logic           en;
  logic [LAT-1:0] valid_q;
  logic           out_valid_q;
  logic           skid_valid_q;

  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[LAT-2:0], in_valid_i};
    end
  end

  // Front end, rotation chain and back end.
  pmp_rot_t       rot   [CORDIC_STAGES+1];
  pmp_ctrl_t      ctrl  [CORDIC_STAGES+1];
  logic [DMW-1:0] dmag  [CORDIC_STAGES+1];
  logic [DMW-1:0] quot  [CORDIC_STAGES+1];
  logic [5:0]     rem   [CORDIC_STAGES+1];

  pmp_front #(
    .FRACTION_BITS(FRACTION_BITS),
    .DMW          (DMW)
  ) u_front (
    .clk_i       (clk_i),
    .en_i        (en),
    .latitude_i  (latitude_i),
    .longitude_i (longitude_i),
    .center_lon_i(center_lon_q),
    .lat_offset_i(lat_offset_q),
    .lat_gain_i  (lat_gain_q),
    .rot_o       (rot[0]),
    .ctrl_o      (ctrl[0]),
    .dmag_o      (dmag[0])
  );

  assign quot[0] = '0;
  assign rem[0]  = '0;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    pmp_cell #(
      .STAGE_IDX(i),
      .DMW      (DMW),
      .BPC      (BPC)
    ) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .rot_i (rot[i]),
      .ctrl_i(ctrl[i]),
      .dmag_i(dmag[i]),
      .quot_i(quot[i]),
      .rem_i (rem[i]),
      .rot_o (rot[i+1]),
      .ctrl_o(ctrl[i+1]),
      .dmag_o(dmag[i+1]),
      .quot_o(quot[i+1]),
      .rem_o (rem[i+1])
    );
  end

  logic signed [PIX_W-1:0] res_x;
  logic signed [PIX_W-1:0] res_y;
  logic                    res_clip;

  pmp_back #(
    .FRACTION_BITS(FRACTION_BITS),
    .DMW          (DMW)
  ) u_back (
    .clk_i         (clk_i),
    .en_i          (en),
    .rot_i         (rot[CORDIC_STAGES]),
    .ctrl_i        (ctrl[CORDIC_STAGES]),
    .quot_i        (quot[CORDIC_STAGES]),
    .rem_i         (rem[CORDIC_STAGES]),
    .radius_at_45_i(radius_at_45_q),
    .origin_x_i    (origin_x_q),
    .origin_y_i    (origin_y_q),
    .pixel_x_o     (res_x),
    .pixel_y_o     (res_y),
    .clipped_o     (res_clip)
  );

  // Output register with a skid entry behind it.
  logic                    out_fire;
  logic                    res_new;
  logic signed [PIX_W-1:0] out_x_q;
  logic signed [PIX_W-1:0] out_y_q;
  logic                    out_clip_q;
  logic signed [PIX_W-1:0] skid_x_q;
  logic signed [PIX_W-1:0] skid_y_q;
  logic                    skid_clip_q;

  assign out_fire = out_valid_q && !out_stall_i;
  assign res_new  = en && valid_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (res_new) begin
      if (!out_valid_q || out_fire) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_x_q    <= skid_x_q;
        out_y_q    <= skid_y_q;
        out_clip_q <= skid_clip_q;
      end
    end else if (res_new) begin
      if (!out_valid_q || out_fire) begin
        out_x_q    <= res_x;
        out_y_q    <= res_y;
        out_clip_q <= res_clip;
      end else begin
        skid_x_q    <= res_x;
        skid_y_q    <= res_y;
        skid_clip_q <= res_clip;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_x_o   = out_x_q;
  assign pixel_y_o   = out_y_q;
  assign clipped_o   = out_clip_q;

endmodule

// ===== verif/pmp_projection_check.sv =====
module pmp_projection_check #(
  parameter int CORDIC_STAGES = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pmp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [pmp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [pmp_pkg::LAT_W-1:0]     latitude_i,
  input  logic [pmp_pkg::LON_W-1:0]     longitude_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [pmp_pkg::PIX_W-1:0]     pixel_x_i,
  input  logic [pmp_pkg::PIX_W-1:0]     pixel_y_i,
  input  logic                          clipped_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import pmp_pkg::*;

  // Pi/180 in Q32 and the inverse rotation gain in Q30.
  localparam longint DEG_RAD_Q32 = 64'sd74961321;
  localparam longint ROT_GAIN_Q30 = 64'sd652032874;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic        clip;
  } pixel_t;

  // Arctangent of 2^-i in Q30 radians, truncated.
  longint rot_atan [32] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
    65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
    15, 8, 4, 2, 1, 0
  };

  // Shadow copy of the configuration registers.
  logic [24:0] center_lon;
  logic [15:0] origin_x;
  logic [15:0] origin_y;
  logic [15:0] radius_at_45;
  logic [23:0] lat_offset;
  logic [17:0] lat_gain;

  // Pixels owed by the block, oldest first.
  pixel_t pending_pixels [$];

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    fail_count_o++;
  endtask

  // Arithmetic shift right that rounds toward zero.
  function automatic longint shift_trunc(longint v, int s);
    if (v < 0) begin
      return -((-v) >>> s);
    end
    return v >>> s;
  endfunction

  // Product of a Q.F radius and a Q30 trig value, truncated toward zero.
  function automatic longint scale_q30(longint r, longint t);
    logic [127:0] mag;
    longint mr, mt;
    mr = (r < 0) ? -r : r;
    mt = (t < 0) ? -t : t;
    mag = ({64'd0, mr} * {64'd0, mt}) >> 30;
    if ((r < 0) != (t < 0)) begin
      return -longint'(mag[63:0]);
    end
    return longint'(mag[63:0]);
  endfunction

  // One coordinate: origin plus offset, truncated and saturated; bit 16 flags a clip.
  function automatic logic [16:0] to_pixel(longint origin, longint r, longint trig);
    longint s, v;
    s = (origin <<< FRACTION_BITS) + scale_q30(r, trig);
    v = shift_trunc(s, FRACTION_BITS);
    if (v > 32767) begin
      return {1'b1, 16'h7fff};
    end
    if (v < -32768) begin
      return {1'b1, 16'h8000};
    end
    return {1'b0, v[15:0]};
  endfunction

  // Projects one point with the current register settings.
  function automatic pixel_t project_point(logic [23:0] lat_bits, logic [24:0] lon_bits);
    longint lat, lon, center, d, r, a, z, x, y, nx;
    longint one, full, half, quarter;
    bit flip;
    logic [16:0] px, py;
    pixel_t res;
    lat = longint'($signed(lat_bits));
    lon = longint'($signed(lon_bits));
    center = longint'($signed(center_lon));
    one = longint'(1) <<< FRACTION_BITS;
    full = 360 * one;
    half = 180 * one;
    quarter = 90 * one;
    flip = 1'b0;

    // Radius in Q.F pixels; negative past the pole.
    d = longint'(lat_offset) - shift_trunc(longint'(lat_gain) * lat, FRACTION_BITS);
    r = (longint'(radius_at_45) * d) / 45;

    // Wrap the angle into [-180,180), then fold into [-90,90].
    a = (lon - center) % full;
    if (a >= half) begin
      a = a - full;
    end
    if (a < -half) begin
      a = a + full;
    end
    if (a > quarter) begin
      a = a - half;
      flip = 1'b1;
    end
    if (a < -quarter) begin
      a = a + half;
      flip = 1'b1;
    end
    z = shift_trunc(a * DEG_RAD_Q32, FRACTION_BITS + 2);

    // Rotation-mode CORDIC with floor shifts.
    x = ROT_GAIN_Q30;
    y = 0;
    for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - rot_atan[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + rot_atan[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end

    px = to_pixel(longint'($signed(origin_x)), r, y);
    py = to_pixel(longint'($signed(origin_y)), r, x);
    res.x = px[15:0];
    res.y = py[15:0];
    res.clip = px[16] | py[16];
    return res;
  endfunction

  // Track register writes, check each delivered result, predict each accepted request.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    pixel_t want;
    if (!rst_ni) begin
      center_lon <= 25'd655360;
      origin_x <= 16'd447;
      origin_y <= 16'hf220;
      radius_at_45 <= 16'd4126;
      lat_offset <= 24'd6193152;
      lat_gain <= 18'd72090;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_CENTER_LON: begin
            center_lon <= cfg_data_i[24:0];
          end
          CFG_ORIGIN_X: begin
            origin_x <= cfg_data_i[15:0];
          end
          CFG_ORIGIN_Y: begin
            origin_y <= cfg_data_i[15:0];
          end
          CFG_RADIUS_AT_45: begin
            radius_at_45 <= cfg_data_i[15:0];
          end
          CFG_LAT_OFFSET: begin
            lat_offset <= cfg_data_i[23:0];
          end
          CFG_LAT_GAIN: begin
            lat_gain <= cfg_data_i[17:0];
          end
          default: begin
          end
        endcase
      end

      if (out_valid_i && !out_stall_i) begin
        if (pending_pixels.size() == 0) begin
          report_mismatch($sformatf("unexpected result x=%0d y=%0d clipped=%0b",
                                    $signed(pixel_x_i), $signed(pixel_y_i), clipped_i));
        end else begin
          want = pending_pixels.pop_front();
          if (pixel_x_i !== want.x || pixel_y_i !== want.y || clipped_i !== want.clip) begin
            report_mismatch($sformatf(
              "got x=%0d y=%0d clipped=%0b, expected x=%0d y=%0d clipped=%0b",
              $signed(pixel_x_i), $signed(pixel_y_i), clipped_i,
              $signed(want.x), $signed(want.y), want.clip));
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        pending_pixels.push_back(project_point(latitude_i, longitude_i));
      end
      pending_o = pending_pixels.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pmp_pkg::*;

  localparam int CORDIC_STAGES = 16;
  localparam int FRACTION_BITS = 16;
  localparam int PIPE_DEPTH = 15 + CORDIC_STAGES;
  localparam int RANDOM_PHASES = 5;
  localparam int POINTS_PER_PHASE = 100;
  localparam int HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DEG = 65536;

  // Register indexes past the defined set; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic signed [LAT_W-1:0] latitude;
  logic signed [LON_W-1:0] longitude;
  logic                  out_valid;
  logic                  out_stall;
  logic signed [PIX_W-1:0] pixel_x;
  logic signed [PIX_W-1:0] pixel_y;
  logic                  clipped;
  logic                  hold_armed;
  int                    fail_count;
  int                    pending;
  int                    burst_left = 0;
  int unsigned           cycle_count = 0;

  polar_map_projection #(
    .CORDIC_STAGES(CORDIC_STAGES),
    .FRACTION_BITS(FRACTION_BITS)
  ) uut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .cfg_we_i(cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall),
    .latitude_i(latitude),
    .longitude_i(longitude),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .pixel_x_o(pixel_x),
    .pixel_y_o(pixel_y),
    .clipped_o(clipped)
  );

  pmp_projection_check #(
    .CORDIC_STAGES(CORDIC_STAGES),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_proj_check (
    .clk_i(clk),
    .rst_ni(rst_n),
    .cfg_we_i(cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data),
    .in_valid_i(in_valid),
    .in_stall_i(in_stall),
    .latitude_i(latitude),
    .longitude_i(longitude),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .pixel_x_i(pixel_x),
    .pixel_y_i(pixel_y),
    .clipped_i(clipped),
    .fail_count_o(fail_count),
    .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: stretches of free flow, random stalls and solid stalls, plus one
  // long hold-off once the random traffic starts so the pipeline backs up.
  initial begin : receiver
    int seg_len;
    int mode;
    int pct;
    bit held;
    held = 1'b0;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_armed && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 9);
        seg_len = $urandom_range(5, 60);
        if (mode < 3) begin
          pct = 0;
        end else if (mode < 8) begin
          pct = $urandom_range(10, 60);
        end else if (mode == 8) begin
          pct = 85;
        end else begin
          pct = 100;
          seg_len = $urandom_range(20, 80);
        end
        repeat (seg_len) begin
          out_stall <= ($urandom_range(1, 100) <= pct);
          @(posedge clk);
        end
      end
    end
  end

  // Offers one request and returns at the edge where it is taken. Requests go
  // out in bursts with idle gaps between them.
  task automatic send_point(int lat, int lon);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    latitude <= 24'(lat);
    longitude <= 25'(lon);
    do @(posedge clk); while (in_stall);
  endtask

  // Stops offering and waits until every predicted result has been delivered.
  task automatic drain;
    in_valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 25'(value);
    @(posedge clk);
  endtask

  // Writes all registers while the block is idle, plus the two unused indexes.
  task automatic apply_settings(int center, int ox, int oy, int rad, int offs, int gain);
    drain();
    write_reg(CFG_CENTER_LON, center);
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_SPARE_LO, int'($urandom));
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_RADIUS_AT_45, rad);
    write_reg(CFG_LAT_OFFSET, offs);
    write_reg(CFG_SPARE_HI, int'($urandom));
    write_reg(CFG_LAT_GAIN, gain);
    cfg_we <= 1'b0;
  endtask

  // Uniform in [lo, hi], with the ends themselves drawn more often.
  function automatic int pick_value(int lo, int hi);
    case ($urandom_range(0, 7))
      0: return lo;
      1: return hi;
      default: return lo + int'($urandom_range(0, hi - lo));
    endcase
  endfunction

  initial begin : stimulus
    int lat;
    int lon;
    bit wide;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    latitude <= '0;
    longitude <= '0;
    hold_armed <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: poles, date line, fold boundaries at +/-90 and 180
    // from the centre meridian, full-width values beyond the stated range,
    // and latitudes that put the point past the pole.
    send_point(0, 0);
    send_point(90 * DEG, 0);
    send_point(-90 * DEG, 0);
    send_point(0, 180 * DEG);
    send_point(0, -180 * DEG);
    send_point(45 * DEG, 10 * DEG + 90 * DEG);
    send_point(45 * DEG, 10 * DEG - 90 * DEG);
    send_point(45 * DEG, 10 * DEG + 180 * DEG);
    send_point(-8388608, -16777216);
    send_point(8388607, 16777215);
    send_point(5630185, 3000000);
    send_point(-1, 1);

    // Register maxima: huge radius, coordinates saturate.
    apply_settings(180 * DEG, -32768, 32767, 65535, 16777215, 262143);
    send_point(0, 0);
    send_point(90 * DEG, 180 * DEG);
    send_point(-90 * DEG, -180 * DEG);
    send_point(8388607, 0);
    send_point(-8388608, 16777215);

    // Register minima: zero radius, every point lands on the origin.
    apply_settings(-180 * DEG, 32767, -32768, 0, 0, 0);
    send_point(0, 0);
    send_point(90 * DEG, -180 * DEG);
    send_point(-1, -1);

    // Random traffic; even phases keep the map near pixel range, odd ones roam.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p % 2 == 0) begin
        apply_settings(pick_value(-180 * DEG, 180 * DEG), pick_value(-2000, 2000),
                       pick_value(-6000, 2000), pick_value(0, 5000),
                       pick_value(0, 200 * DEG), pick_value(0, 2 * DEG));
      end else begin
        apply_settings(pick_value(-180 * DEG, 180 * DEG), pick_value(-32768, 32767),
                       pick_value(-32768, 32767), pick_value(0, 65535),
                       pick_value(0, 16777215), pick_value(0, 262143));
      end
      if (p == 0) begin
        hold_armed <= 1'b1;
      end
      for (int n = 0; n < POINTS_PER_PHASE; n++) begin
        wide = ($urandom_range(0, 9) == 0);
        if (wide) begin
          lat = int'($urandom);
          lon = int'($urandom);
        end else begin
          lat = int'($urandom_range(0, 180 * DEG)) - 90 * DEG;
          lon = int'($urandom_range(0, 360 * DEG)) - 180 * DEG;
        end
        send_point(lat, lon);
      end
    end

    drain();
    repeat (PIPE_DEPTH + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
